// File: sv/mpsd_pkg.sv
`default_nettype none
package mpsd_pkg;

   localparam int LEVEL_W   = 16;
   localparam int COUNT_W   = 17;
   localparam int NUM_ROWS  = 4;
   localparam int NUM_CHAN  = 4;
   localparam int NUM_LEVEL = NUM_ROWS * NUM_CHAN;

   localparam logic [COUNT_W-1:0] PERIOD_RESET = 17'h10000;
   localparam logic [1:0]         COL_LAST     = 2'b11;

   typedef enum logic [1:0] {
      MODE_WRITE   = 2'd0,
      MODE_SERVICE = 2'd1,
      MODE_TICK    = 2'd2,
      MODE_UNUSED  = 2'd3
   } mode_type;

   typedef struct packed {
      logic [1:0]         mode;
      logic [1:0]         row;
      logic [1:0]         col;
      logic [LEVEL_W-1:0] level;
   } item_type;

   typedef struct packed {
      logic                sel_low;
      logic                sel_high;
      logic [NUM_CHAN-1:0] pwm_bits;
      logic [1:0]          phase;
   } result_type;

endpackage
`default_nettype wire

// File: sv/multiplexed_pwm_scan_driver_top.sv
`default_nettype none
// A transaction accepted into the input register is computed combinationally from it and
// is registered onto rsp_* when it advances, which a result held by rsp_stall can delay.
// Throughput: one transaction per cycle while rsp_stall is low; while a result is held by
// rsp_stall, req_stall rises as soon as the input register is full.
// Reset (synchronous, active high) clears the level store, compare values,
// mux phase and PWM counter, and sets the period to 65536.
module multiplexed_pwm_scan_driver_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_mode,
   input  wire logic [1:0]  req_row,
   input  wire logic [1:0]  req_col,
   input  wire logic [15:0] req_level,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_sel_low,
   output logic             rsp_sel_high,
   output logic [3:0]       rsp_pwm_bits,
   output logic [1:0]       rsp_phase,
   input  wire logic        csr_wr_en,
   input  wire logic [16:0] csr_wr_data
);
   import mpsd_pkg::*;

   logic [COUNT_W-1:0] period_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_ff;
   result_type         result;
   item_type           req_item, item;
   logic               item_valid, advance, fire;

   assign req_item.mode  = req_mode;
   assign req_item.row   = req_row;
   assign req_item.col   = req_col;
   assign req_item.level = req_level;

   assign advance = !rsp_valid_ff || !rsp_stall;
   assign fire    = item_valid && advance;

   mpsd_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   mpsd_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (item),
      .period (period_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= PERIOD_RESET;
      end else if (csr_wr_en) begin
         period_ff <= csr_wr_data;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = item_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_sel_low  = rsp_ff.sel_low;
   assign rsp_sel_high = rsp_ff.sel_high;
   assign rsp_pwm_bits = rsp_ff.pwm_bits;
   assign rsp_phase    = rsp_ff.phase;

endmodule
`default_nettype wire

// File: sv/mpsd_in_stage.sv
`default_nettype none
module mpsd_in_stage (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire mpsd_pkg::item_type req_item,
   input  wire logic              advance,
   output logic                   item_valid,
   output mpsd_pkg::item_type     item
);
   import mpsd_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff;

   // hold the transaction while the result side is blocked
   assign req_stall  = valid_ff && !advance;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (!req_stall) begin
         valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         item_ff <= req_item;
      end
   end

endmodule
`default_nettype wire

// File: sv/mpsd_engine.sv
`default_nettype none
module mpsd_engine (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         fire,
   input  wire mpsd_pkg::item_type           item,
   input  wire logic [mpsd_pkg::COUNT_W-1:0] period,
   output mpsd_pkg::result_type              result
);
   import mpsd_pkg::*;

   logic [LEVEL_W-1:0] store_ff [NUM_LEVEL];
   logic [LEVEL_W-1:0] cmp_ff   [NUM_CHAN];
   logic [1:0]         phase_ff, phase_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [1:0]         store_row, store_col;
   logic [3:0]         store_idx;
   logic [NUM_CHAN-1:0] bits;
   mode_type           mode;

   assign mode      = mode_type'(item.mode);
   assign store_col = COL_LAST - item.col;
   assign store_row = item.row ^ {1'b0, item.col[0]};
   assign store_idx = {store_row, store_col};

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      case (mode)
         MODE_SERVICE: begin
            phase_in = phase_ff + 2'd1;
            count_in = '0;
         end
         MODE_TICK: begin
            // wrap after the counter reaches the top count
            if (count_ff >= period) begin
               count_in = '0;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      bits = '0;
      for (int i = 0; i < NUM_CHAN; i++) begin
         bits[i] = (mode == MODE_TICK) && (count_ff < {1'b0, cmp_ff[i]});
      end
   end

   always_comb begin
      result.pwm_bits = bits;
      result.phase    = phase_in;
      result.sel_low  = (phase_in == 2'd0) || (phase_in == 2'd1);
      result.sel_high = (phase_in == 2'd0) || (phase_in == 2'd3);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_LEVEL; i++) begin
            store_ff[i] <= '0;
         end
         for (int i = 0; i < NUM_CHAN; i++) begin
            cmp_ff[i] <= '0;
         end
         phase_ff <= '0;
         count_ff <= '0;
      end else if (fire) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         if (mode == MODE_WRITE) begin
            store_ff[store_idx] <= item.level;
         end
         if (mode == MODE_SERVICE) begin
            for (int i = 0; i < NUM_CHAN; i++) begin
               cmp_ff[i] <= store_ff[{phase_in, i[1:0]}];
            end
         end
      end
   end

endmodule
`default_nettype wire
